/* rtl/mtfl_pkg.sv */
package mtfl_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int TYPE_W    = 2;
    localparam int KEY_W     = 32;
    localparam int STATUS_W  = 2;
    localparam int LEN_W     = 5;

    typedef logic [TYPE_W-1:0]   req_type_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam req_type_t REQ_INSERT = 2'd0;
    localparam req_type_t REQ_FIND   = 2'd1;
    localparam req_type_t REQ_DELETE = 2'd2;

    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_MISS  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;
    localparam status_t ST_FULL  = 2'd3;

    typedef struct packed {
        req_type_t                req_type;
        logic signed [KEY_W-1:0]  key;
    } mtfl_req_t;

    typedef struct packed {
        status_t           status;
        logic [LEN_W-1:0]  length;
    } mtfl_rsp_t;

    typedef struct packed {
        logic load_req;
        logic capture;
        logic apply;
    } mtfl_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_APPLY
    } mtfl_state_t;

endpackage

/* rtl/move_to_front_list_core.sv */
// Move-to-front list of up to DEPTH signed 32-bit keys, front entry newest.
// Input channel (s_valid/s_ready/s_req): one request carrying req_type
// (insert, find and move to front, delete first match) and a key.
// Result channel (m_valid/m_ready/m_rsp): exactly one result per request,
// holding a status (done, not found, list empty, list full) and the number
// of entries held after the request.
// Timing: a request is registered on acceptance, every cell compares it
// in parallel in the next cycle, and the update state after that shifts
// the cells and loads the result register once the output register is free.
// A new request is taken in that same update cycle, so a request is not
// accepted while the one before it is still in the compare stage or
// waiting in the prefix/shift stage that follows it.
// Reset (aresetn low, synchronous) empties the list and drops any pending
// result; cell contents are not cleared.
// When the receiver stalls, the result is held in the output register and
// one further request may be accepted; it waits in the update stage until
// the held result is taken.
module move_to_front_list_core #(
    parameter int DEPTH = mtfl_pkg::DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mtfl_pkg::mtfl_req_t s_req,
    output logic                m_valid,
    input  logic                m_ready,
    output mtfl_pkg::mtfl_rsp_t m_rsp
);

    mtfl_pkg::mtfl_cmd_t cmd;

    mtfl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    mtfl_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_req   (s_req),
        .m_rsp   (m_rsp)
    );

endmodule

/* rtl/mtfl_ctrl.sv */
module mtfl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output mtfl_pkg::mtfl_cmd_t cmd
);

    mtfl_pkg::mtfl_state_t state_reg, state_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  can_write;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mtfl_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        can_write    = !m_valid_reg || m_ready;
        state_next   = state_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        case (state_reg)
            mtfl_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = mtfl_pkg::ST_MATCH;
                end
            end
            mtfl_pkg::ST_MATCH: begin
                cmd.capture = 1'b1;
                state_next  = mtfl_pkg::ST_APPLY;
            end
            mtfl_pkg::ST_APPLY: begin
                // hold the update until the output register is free
                if (can_write) begin
                    cmd.apply  = 1'b1;
                    s_ready    = 1'b1;
                    state_next = s_valid ? mtfl_pkg::ST_MATCH : mtfl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mtfl_pkg::ST_IDLE;
            end
        endcase
        cmd.load_req = s_valid && s_ready;

        if (cmd.apply) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

/* rtl/mtfl_datapath.sv */
module mtfl_datapath #(
    parameter int DEPTH = mtfl_pkg::DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  mtfl_pkg::mtfl_cmd_t cmd,
    input  mtfl_pkg::mtfl_req_t s_req,
    output mtfl_pkg::mtfl_rsp_t m_rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LVL   = $clog2(DEPTH);

    mtfl_pkg::mtfl_req_t               req_reg;
    logic signed [mtfl_pkg::KEY_W-1:0] cell_reg  [DEPTH];
    logic signed [mtfl_pkg::KEY_W-1:0] cell_next [DEPTH];
    logic [DEPTH-1:0]                  match_reg, match_next;
    logic [DEPTH-1:0]                  pfx [LVL+1];
    logic [DEPTH-1:0]                  hit_upto, hit_before;
    logic                              hit;
    logic [CNT_W-1:0]                  count_reg, count_next;
    mtfl_pkg::mtfl_rsp_t               rsp_reg, rsp_next;
    logic                              full, empty;

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg <= s_req;
        end
        if (cmd.capture) begin
            match_reg <= match_next;
        end
        if (cmd.apply) begin
            cell_reg <= cell_next;
            rsp_reg  <= rsp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.apply) begin
            count_reg <= count_next;
        end
    end

    // compare every held cell against the key
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            match_next[i] = (cell_reg[i] == req_reg.key) && (count_reg > CNT_W'(i));
        end
    end

    // parallel prefix OR: hit_upto[i] is set when a match lies at or before i
    always_comb begin
        pfx[0] = match_reg;
        for (int l = 0; l < LVL; l++) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (i >= (1 << l)) begin
                    pfx[l+1][i] = pfx[l][i] | pfx[l][i - (1 << l)];
                end else begin
                    pfx[l+1][i] = pfx[l][i];
                end
            end
        end
        hit_upto   = pfx[LVL];
        hit_before = {hit_upto[DEPTH-2:0], 1'b0};
        hit        = hit_upto[DEPTH-1];
    end

    always_comb begin
        full       = (count_reg == CNT_W'(DEPTH));
        empty      = (count_reg == '0);
        cell_next  = cell_reg;
        count_next = count_reg;
        rsp_next.status = mtfl_pkg::ST_DONE;
        case (req_reg.req_type)
            mtfl_pkg::REQ_INSERT: begin
                if (full) begin
                    rsp_next.status = mtfl_pkg::ST_FULL;
                end else begin
                    cell_next[0] = req_reg.key;
                    for (int i = 1; i < DEPTH; i++) begin
                        cell_next[i] = cell_reg[i-1];
                    end
                    count_next = count_reg + CNT_W'(1);
                end
            end
            mtfl_pkg::REQ_FIND: begin
                if (empty) begin
                    rsp_next.status = mtfl_pkg::ST_EMPTY;
                end else if (!hit) begin
                    rsp_next.status = mtfl_pkg::ST_MISS;
                end else begin
                    // advance every cell up to the match by one, key to the front
                    cell_next[0] = req_reg.key;
                    for (int i = 1; i < DEPTH; i++) begin
                        if (!hit_before[i]) begin
                            cell_next[i] = cell_reg[i-1];
                        end
                    end
                end
            end
            mtfl_pkg::REQ_DELETE: begin
                if (empty) begin
                    rsp_next.status = mtfl_pkg::ST_EMPTY;
                end else if (!hit) begin
                    rsp_next.status = mtfl_pkg::ST_MISS;
                end else begin
                    // close the gap from the match onwards
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        if (hit_upto[i]) begin
                            cell_next[i] = cell_reg[i+1];
                        end
                    end
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default: begin
                rsp_next.status = mtfl_pkg::ST_DONE;
            end
        endcase
        rsp_next.length = mtfl_pkg::LEN_W'(count_next);
    end

    assign m_rsp = rsp_reg;

endmodule

/* rtl/mtfl_checker.sv */
module mtfl_checker #(
    parameter int DEPTH = mtfl_pkg::DEPTH_DEF
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input mtfl_pkg::mtfl_rsp_t m_rsp
);

    localparam logic SMALL = (DEPTH < 32);

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // one request at a time: no request taken right after an acceptance
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted in the compare cycle");

    // a stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_rsp)))
        else $error("stalled result changed");

    a_full_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (SMALL && m_valid && m_rsp.status == mtfl_pkg::ST_FULL)
            |-> (m_rsp.length == mtfl_pkg::LEN_W'(DEPTH)))
        else $error("full status with short list");

    a_empty_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rsp.status == mtfl_pkg::ST_EMPTY) |-> (m_rsp.length == '0))
        else $error("empty status with entries held");

endmodule

bind move_to_front_list_core mtfl_checker #(
    .DEPTH (DEPTH)
) u_mtfl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_rsp   (m_rsp)
);

/* verif/move_to_front_list_core_tb.sv */
module move_to_front_list_core_tb;

    localparam int                  LIST_DEPTH = mtfl_pkg::DEPTH_DEF;
    localparam mtfl_pkg::req_type_t REQ_NONE   = 2'd3;
    localparam int                  N_DIR      = 28;
    localparam int                  N_RANDOM   = 405;
    localparam int                  QUIET_FROM = 360;
    localparam int                  HOLD_AT    = 150;
    localparam int                  LONG_HOLD  = 80;
    localparam int                  MAX_SHOWN  = 10;

    typedef struct {
        mtfl_pkg::mtfl_req_t req;
        bit                  typed;
        mtfl_pkg::mtfl_rsp_t rsp;
    } dir_row_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    mtfl_pkg::mtfl_req_t s_req   = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    mtfl_pkg::mtfl_rsp_t m_rsp;

    logic signed [mtfl_pkg::KEY_W-1:0] mtf_keys [LIST_DEPTH];
    int                  mtf_len = 0;
    mtfl_pkg::mtfl_rsp_t rsp_q[$];
    int                  n_fail = 0;
    int                  n_random = 0;
    bit                  quiet = 1'b0;
    bit                  long_hold_go = 1'b0;
    bit                  long_hold_fired = 1'b0;

    move_to_front_list_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #3000000;
        $display("move_to_front_list_core_tb failed");
        $finish;
    end

    // Apply one request to the list copy and return the status and length it earns.
    function automatic mtfl_pkg::mtfl_rsp_t mtf_apply(mtfl_pkg::mtfl_req_t r);
        mtfl_pkg::mtfl_rsp_t o;
        int                  hit;
        o.status = mtfl_pkg::ST_DONE;
        hit = -1;
        for (int i = 0; i < mtf_len; i++) begin
            if (hit < 0 && mtf_keys[i] == r.key) hit = i;
        end
        case (r.req_type)
            mtfl_pkg::REQ_INSERT: begin
                if (mtf_len >= LIST_DEPTH) begin
                    o.status = mtfl_pkg::ST_FULL;
                end else begin
                    for (int i = mtf_len; i > 0; i--) mtf_keys[i] = mtf_keys[i-1];
                    mtf_keys[0] = r.key;
                    mtf_len++;
                end
            end
            mtfl_pkg::REQ_FIND, mtfl_pkg::REQ_DELETE: begin
                if (mtf_len == 0) begin
                    o.status = mtfl_pkg::ST_EMPTY;
                end else if (hit < 0) begin
                    o.status = mtfl_pkg::ST_MISS;
                end else if (r.req_type == mtfl_pkg::REQ_FIND) begin
                    for (int i = hit; i > 0; i--) mtf_keys[i] = mtf_keys[i-1];
                    mtf_keys[0] = r.key;
                end else begin
                    for (int i = hit; i + 1 < mtf_len; i++) mtf_keys[i] = mtf_keys[i+1];
                    mtf_len--;
                end
            end
            default: ;
        endcase
        o.length = mtf_len[mtfl_pkg::LEN_W-1:0];
        return o;
    endfunction

    function automatic dir_row_t mk_row(mtfl_pkg::req_type_t t,
                                        logic [mtfl_pkg::KEY_W-1:0] k, bit typed,
                                        mtfl_pkg::status_t st, int len);
        dir_row_t row;
        row.req.req_type = t;
        row.req.key      = k;
        row.typed        = typed;
        row.rsp.status   = st;
        row.rsp.length   = len[mtfl_pkg::LEN_W-1:0];
        return row;
    endfunction

    // Half the time a key already held, so finds and deletes hit; the rest from a
    // pool of edge values or fully random.
    function automatic logic signed [mtfl_pkg::KEY_W-1:0] pick_key();
        logic signed [mtfl_pkg::KEY_W-1:0] pool [8];
        int                                sel;
        pool = '{32'sh0, -32'sd1, 32'sd1, 32'sh7FFFFFFF, 32'sh80000000,
                 32'sh55555555, 32'shAAAAAAAA, 32'sd42};
        sel = $urandom_range(0, 9);
        if (sel < 5 && mtf_len > 0) return mtf_keys[$urandom_range(0, mtf_len - 1)];
        if (sel < 8) return pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    task automatic send_req(input mtfl_pkg::mtfl_req_t r, input bit typed,
                            input mtfl_pkg::mtfl_rsp_t lit);
        mtfl_pkg::mtfl_rsp_t p;
        s_valid <= 1'b1;
        s_req   <= r;
        do @(posedge aclk); while (!s_ready);
        p = mtf_apply(r);
        rsp_q.push_back(typed ? lit : p);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
    endtask

    initial begin : stim
        dir_row_t            tab [N_DIR];
        mtfl_pkg::mtfl_req_t r;
        int                  w;
        int                  ins_lim;

        tab[0]  = mk_row(mtfl_pkg::REQ_FIND,   32'h00000000, 1'b1, mtfl_pkg::ST_EMPTY, 0);
        tab[1]  = mk_row(mtfl_pkg::REQ_DELETE, 32'h7FFFFFFF, 1'b1, mtfl_pkg::ST_EMPTY, 0);
        tab[2]  = mk_row(REQ_NONE,             32'hFFFFFFFF, 1'b1, mtfl_pkg::ST_DONE,  0);
        tab[3]  = mk_row(mtfl_pkg::REQ_INSERT, 32'h7FFFFFFF, 1'b1, mtfl_pkg::ST_DONE,  1);
        tab[4]  = mk_row(mtfl_pkg::REQ_INSERT, 32'h80000000, 1'b1, mtfl_pkg::ST_DONE,  2);
        tab[5]  = mk_row(mtfl_pkg::REQ_FIND,   32'h80000000, 1'b1, mtfl_pkg::ST_DONE,  2);
        tab[6]  = mk_row(mtfl_pkg::REQ_FIND,   32'h7FFFFFFF, 1'b1, mtfl_pkg::ST_DONE,  2);
        tab[7]  = mk_row(mtfl_pkg::REQ_FIND,   32'hFFFFFFFF, 1'b1, mtfl_pkg::ST_MISS,  2);
        tab[8]  = mk_row(mtfl_pkg::REQ_DELETE, 32'h00000000, 1'b1, mtfl_pkg::ST_MISS,  2);
        tab[9]  = mk_row(mtfl_pkg::REQ_INSERT, 32'h7FFFFFFF, 1'b1, mtfl_pkg::ST_DONE,  3);
        tab[10] = mk_row(mtfl_pkg::REQ_DELETE, 32'h7FFFFFFF, 1'b1, mtfl_pkg::ST_DONE,  2);
        // fill to the brim; the oldest entry ends up at the back
        for (int i = 11; i < 25; i++) begin
            tab[i] = mk_row(mtfl_pkg::REQ_INSERT, 32'(i - 18), 1'b0, mtfl_pkg::ST_DONE, 0);
        end
        tab[25] = mk_row(mtfl_pkg::REQ_INSERT, 32'h00000000, 1'b1, mtfl_pkg::ST_FULL,
                         LIST_DEPTH);
        tab[26] = mk_row(mtfl_pkg::REQ_FIND,   32'h80000000, 1'b0, mtfl_pkg::ST_DONE, 0);
        tab[27] = mk_row(mtfl_pkg::REQ_DELETE, 32'h80000000, 1'b0, mtfl_pkg::ST_DONE, 0);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIR; i++) send_req(tab[i].req, tab[i].typed, tab[i].rsp);

        while (n_random < N_RANDOM) begin
            // alternate filling and draining spells so both full and empty recur
            ins_lim = ((n_random / 60) % 2 == 0) ? 62 : 22;
            w = $urandom_range(0, 99);
            if (w < 4)                                  r.req_type = REQ_NONE;
            else if (w < ins_lim)                       r.req_type = mtfl_pkg::REQ_INSERT;
            else if (w < ins_lim + (100 - ins_lim) / 2) r.req_type = mtfl_pkg::REQ_FIND;
            else                                        r.req_type = mtfl_pkg::REQ_DELETE;
            r.key = pick_key();
            if (r.req_type != REQ_NONE) n_random++;
            quiet = (n_random >= QUIET_FROM);
            if (n_random >= HOLD_AT && !long_hold_fired) begin
                long_hold_fired = 1'b1;
                long_hold_go    = 1'b1;
            end
            send_req(r, 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (rsp_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (n_fail == 0) begin
            $display("move_to_front_list_core_tb passed");
        end else begin
            $display("move_to_front_list_core_tb failed");
        end
        $finish;
    end

    initial begin : rsp_drain
        repeat (2) @(posedge aclk);
        forever begin
            if (long_hold_go) begin
                // hold off long enough for the block to back up onto its input
                long_hold_go = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : rsp_check
        mtfl_pkg::mtfl_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (rsp_q.size() == 0) begin
                n_fail++;
                if (n_fail <= MAX_SHOWN) begin
                    $display("unexpected result: status %0d length %0d",
                             m_rsp.status, m_rsp.length);
                end
            end else begin
                want = rsp_q.pop_front();
                if (m_rsp.status !== want.status || m_rsp.length !== want.length) begin
                    n_fail++;
                    if (n_fail <= MAX_SHOWN) begin
                        $display("result mismatch: status %0d/%0d length %0d/%0d (exp/act)",
                                 want.status, m_rsp.status, want.length, m_rsp.length);
                    end
                end
            end
        end
    end

endmodule
